FILE: rtl/esgd_pkg.sv
// shared types, codes and constants of the edge swipe gesture detector
// no dependencies; imported by every module of the block

package esgd_pkg;

  // default table depth and debug finger threshold
  localparam int unsigned MaxPointersDef = 32;
  localparam int unsigned DebugFingers   = 5;

  localparam logic [7:0] INVALID_ID = 8'hFF;

  // apb port geometry
  localparam int unsigned ApbAddrW = 5;
  localparam int unsigned ApbDataW = 32;

  // payload widths
  localparam int unsigned CoordW = 20;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned RowW   = TimeW + 2 * CoordW;

  typedef enum logic [1:0] {
    KIND_FIRST_DOWN = 2'd0,
    KIND_EXTRA_DOWN = 2'd1,
    KIND_MOVE       = 2'd2,
    KIND_UP         = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    SW_NONE   = 2'd0,
    SW_TOP    = 2'd1,
    SW_BOTTOM = 2'd2,
    SW_RIGHT  = 2'd3
  } swipe_e;

  typedef enum logic [2:0] {
    REG_EDGE_ZONE      = 3'd0,
    REG_SWIPE_DISTANCE = 3'd1,
    REG_SCREEN_WIDTH   = 3'd2,
    REG_SCREEN_HEIGHT  = 3'd3,
    REG_SWIPE_TIMEOUT  = 3'd4
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SEARCH,
    ST_FOUND,
    ST_TEST,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic [11:0] edge_zone;
    logic [11:0] swipe_distance;
    logic [14:0] screen_width;
    logic [14:0] screen_height;
    logic [15:0] swipe_timeout;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic latch_in;
    logic decode;
    logic step;
    logic hit;
    logic append;
    logic capture;
    logic mem_rd;
    logic test;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    kind_e kind;
    logic  swipe_armed;
    logic  in_range;
    logic  match;
    logic  can_append;
  } sts_t;

endpackage

FILE: rtl/esgd_cfg_regs.sv
// apb configuration registers of the edge swipe gesture detector
// depends on esgd_pkg

module esgd_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [esgd_pkg::ApbAddrW-1:0] paddr,
  input  logic [esgd_pkg::ApbDataW-1:0] pwdata,
  output logic [esgd_pkg::ApbDataW-1:0] prdata,
  output logic                          pready,
  output esgd_pkg::cfg_t                cfg_o
);
  import esgd_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[4:2])
        REG_EDGE_ZONE:      cfg_d.edge_zone      = pwdata[11:0];
        REG_SWIPE_DISTANCE: cfg_d.swipe_distance = pwdata[11:0];
        REG_SCREEN_WIDTH:   cfg_d.screen_width   = pwdata[14:0];
        REG_SCREEN_HEIGHT:  cfg_d.screen_height  = pwdata[14:0];
        REG_SWIPE_TIMEOUT:  cfg_d.swipe_timeout  = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.edge_zone      <= 12'd48;
      cfg_q.swipe_distance <= 12'd48;
      cfg_q.screen_width   <= 15'd1080;
      cfg_q.screen_height  <= 15'd1920;
      cfg_q.swipe_timeout  <= 16'd500;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[4:2])
      REG_EDGE_ZONE:      prdata = {20'd0, cfg_q.edge_zone};
      REG_SWIPE_DISTANCE: prdata = {20'd0, cfg_q.swipe_distance};
      REG_SCREEN_WIDTH:   prdata = {17'd0, cfg_q.screen_width};
      REG_SCREEN_HEIGHT:  prdata = {17'd0, cfg_q.screen_height};
      REG_SWIPE_TIMEOUT:  prdata = {16'd0, cfg_q.swipe_timeout};
      default:            prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/esgd_datapath.sv
// datapath: sample registers, pointer table, start memory, swipe test, result regs
// depends on esgd_pkg; driven by esgd_ctrl commands

module esgd_datapath #(
  parameter int unsigned MAX_POINTERS = esgd_pkg::MaxPointersDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  esgd_pkg::cfg_t       cfg_i,
  input  esgd_pkg::cmd_t       cmd_i,
  output esgd_pkg::sts_t       sts_o,
  input  logic [1:0]           kind_i,
  input  logic signed [7:0]    pointer_id_i,
  input  logic signed [19:0]   x_i,
  input  logic signed [19:0]   y_i,
  input  logic [31:0]          event_time_i,
  input  logic [7:0]           pointer_count_i,
  output logic [1:0]           swipe_o,
  output logic                 debug_fire_o
);
  import esgd_pkg::*;

  localparam int unsigned IdxW = (MAX_POINTERS > 1) ? $clog2(MAX_POINTERS) : 1;
  localparam int unsigned CntW = $clog2(MAX_POINTERS + 1);

  // latched sample
  kind_e       kind_q;
  logic [7:0]  id_q;
  logic [19:0] x_q, y_q;
  logic [31:0] t_q;
  logic [7:0]  pcnt_q;

  // gesture state
  logic [CntW-1:0]         count_q, idx_q;
  logic [IdxW-1:0]         slot_q;
  logic                    swipe_armed_q, debug_armed_q;
  logic [MAX_POINTERS-1:0] row_vld_q;
  swipe_e                  swipe_q;
  swipe_e                  swipe_test;

  // pointer id table and start memory
  logic [7:0]      ids_q [MAX_POINTERS];
  logic [RowW-1:0] mem_q [MAX_POINTERS];
  logic [RowW-1:0] rd_q;
  logic            rd_vld_q;

  logic [1:0] out_swipe_q;
  logic       out_dbg_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      kind_q <= kind_e'(kind_i);
      id_q   <= pointer_id_i;
      x_q    <= x_i;
      y_q    <= y_i;
      t_q    <= event_time_i;
      pcnt_q <= pointer_count_i;
    end
  end

  assign sts_o.kind        = kind_q;
  assign sts_o.swipe_armed = swipe_armed_q;
  assign sts_o.in_range    = idx_q < count_q;
  assign sts_o.match       = ids_q[idx_q[IdxW-1:0]] == id_q;
  assign sts_o.can_append  = (count_q < CntW'(MAX_POINTERS)) && (id_q != INVALID_ID);

  logic dbg_fire;
  assign dbg_fire = (kind_q == KIND_EXTRA_DOWN) && debug_armed_q
                    && (pcnt_q >= 8'(DebugFingers));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q       <= '0;
      idx_q         <= '0;
      slot_q        <= '0;
      swipe_armed_q <= 1'b0;
      debug_armed_q <= 1'b0;
      row_vld_q     <= '0;
      swipe_q       <= SW_NONE;
    end else begin
      if (cmd_i.decode) begin
        idx_q   <= '0;
        swipe_q <= SW_NONE;
        if (kind_q == KIND_FIRST_DOWN) begin
          swipe_armed_q <= 1'b1;
          debug_armed_q <= 1'b1;
          count_q       <= '0;
        end else if (kind_q == KIND_UP) begin
          swipe_armed_q <= 1'b0;
          debug_armed_q <= 1'b0;
        end
      end
      if (cmd_i.step) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.hit) begin
        slot_q <= idx_q[IdxW-1:0];
      end
      if (cmd_i.append) begin
        slot_q  <= count_q[IdxW-1:0];
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.capture) begin
        row_vld_q[slot_q] <= 1'b1;
      end
      if (cmd_i.test) begin
        swipe_q <= swipe_test;
      end
      if (cmd_i.load_out) begin
        if (kind_q == KIND_EXTRA_DOWN && debug_armed_q) begin
          debug_armed_q <= pcnt_q < 8'(DebugFingers);
        end
        if (kind_q == KIND_MOVE) begin
          swipe_armed_q <= swipe_armed_q && (swipe_q == SW_NONE);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.append) begin
      ids_q[count_q[IdxW-1:0]] <= id_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mem_q[slot_q] <= {t_q, y_q, x_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_rd) begin
      rd_q     <= mem_q[slot_q];
      rd_vld_q <= row_vld_q[slot_q];
    end
  end

  // swipe test against the start row; a row never captured reads as zero
  logic [19:0]        st_x, st_y;
  logic [31:0]        st_t, elapsed;
  logic signed [22:0] fx, fy, px, py, zone, travel, hgt, wid;
  logic               in_time, hit_top, hit_bottom, hit_right;

  assign st_x = rd_vld_q ? rd_q[19:0]  : '0;
  assign st_y = rd_vld_q ? rd_q[39:20] : '0;
  assign st_t = rd_vld_q ? rd_q[71:40] : '0;

  assign fx     = $signed({{3{st_x[19]}}, st_x});
  assign fy     = $signed({{3{st_y[19]}}, st_y});
  assign px     = $signed({{3{x_q[19]}}, x_q});
  assign py     = $signed({{3{y_q[19]}}, y_q});
  assign zone   = $signed({7'd0, cfg_i.edge_zone, 4'd0});
  assign travel = $signed({7'd0, cfg_i.swipe_distance, 4'd0});
  assign hgt    = $signed({4'd0, cfg_i.screen_height, 4'd0});
  assign wid    = $signed({4'd0, cfg_i.screen_width, 4'd0});

  // negative elapsed time always counts as in time
  assign elapsed = t_q - st_t;
  assign in_time = elapsed[31] || (elapsed < {16'd0, cfg_i.swipe_timeout});

  assign hit_top    = (fy <= zone) && (py > fy + travel);
  assign hit_bottom = (fy >= hgt - zone) && (py < fy - travel);
  assign hit_right  = (fx >= wid - zone) && (px < fx - travel);

  always_comb begin
    swipe_test = SW_NONE;
    if (in_time) begin
      if (hit_top) begin
        swipe_test = SW_TOP;
      end else if (hit_bottom) begin
        swipe_test = SW_BOTTOM;
      end else if (hit_right) begin
        swipe_test = SW_RIGHT;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_swipe_q <= swipe_q;
      out_dbg_q   <= dbg_fire;
    end
  end

  assign swipe_o      = out_swipe_q;
  assign debug_fire_o = out_dbg_q;

endmodule

FILE: rtl/esgd_ctrl.sv
// controller state machine: request intake, id search, capture or test, result handoff
// depends on esgd_pkg; commands esgd_datapath

module esgd_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  esgd_pkg::sts_t sts_i,
  output esgd_pkg::cmd_t cmd_o
);
  import esgd_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd_o.decode = 1'b1;
        if (sts_i.kind == KIND_UP) begin
          state_d = ST_RESULT;
        end else if (sts_i.kind == KIND_MOVE && !sts_i.swipe_armed) begin
          state_d = ST_RESULT;
        end else begin
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (sts_i.in_range) begin
          if (sts_i.match) begin
            cmd_o.hit = 1'b1;
            state_d   = ST_FOUND;
          end else begin
            cmd_o.step = 1'b1;
          end
        end else if (sts_i.can_append) begin
          cmd_o.append = 1'b1;
          state_d      = ST_FOUND;
        end else begin
          state_d = ST_RESULT;
        end
      end
      ST_FOUND: begin
        if (sts_i.kind == KIND_MOVE) begin
          cmd_o.mem_rd = 1'b1;
          state_d      = ST_TEST;
        end else begin
          cmd_o.capture = 1'b1;
          state_d       = ST_RESULT;
        end
      end
      ST_TEST: begin
        cmd_o.test = 1'b1;
        state_d    = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.load_out || (out_valid_q && !out_ready_i);
  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/edge_swipe_gesture_detector.sv
// flow: for up or an unarmed move a request goes from decode straight to the result state;
// otherwise the id search runs first, then capture or the start-row read and swipe test
// one request at a time; the worst case is set by the linear pointer id search,
// which checks one table entry per cycle
// a new request is taken while the previous result still waits on the output
// reset: asynchronous active low; clears the pointer count, arm flags, row valid bits,
// output valid and restores the register defaults

module edge_swipe_gesture_detector #(
  parameter int unsigned MAX_POINTERS = esgd_pkg::MaxPointersDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [esgd_pkg::ApbAddrW-1:0] paddr,
  input  logic [esgd_pkg::ApbDataW-1:0] pwdata,
  output logic [esgd_pkg::ApbDataW-1:0] prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    kind_i,
  input  logic signed [7:0]             pointer_id_i,
  input  logic signed [19:0]            x_i,
  input  logic signed [19:0]            y_i,
  input  logic [31:0]                   event_time_i,
  input  logic [7:0]                    pointer_count_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    swipe_o,
  output logic                          debug_fire_o
);
  import esgd_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  esgd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  esgd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  esgd_datapath #(
    .MAX_POINTERS (MAX_POINTERS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .kind_i          (kind_i),
    .pointer_id_i    (pointer_id_i),
    .x_i             (x_i),
    .y_i             (y_i),
    .event_time_i    (event_time_i),
    .pointer_count_i (pointer_count_i),
    .swipe_o         (swipe_o),
    .debug_fire_o    (debug_fire_o)
  );

`ifndef SYNTHESIS
  // a loaded result is offered on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |=> out_valid_o)
    else $error("result load did not raise out_valid_o");

  // the block is busy right after taking a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted while previous one in flight");

  // table and memory commands never overlap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.hit, cmd.append, cmd.capture, cmd.mem_rd, cmd.test, cmd.load_out}))
    else $error("overlapping datapath commands");

  // a single request never fires both a swipe and the debug gesture
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && swipe_o != SW_NONE) |-> !debug_fire_o)
    else $error("swipe and debug fired together");
`endif

endmodule
